@@ rtl/core/mer_pkg.sv @@
// Shared constants and types for the midpoint ellipse rasteriser.
package mer_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int RADIUS_BITS_DEF = 10;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    typedef struct packed {
        logic req;
        logic pts_valid;
        logic last;
    } mer_emit_t;

endpackage

@@ rtl/core/mer_mul.sv @@
// Shared unsigned multiplier with a registered product.
module mer_mul
    import mer_pkg::*;
#(
    parameter int A_W = 22
)
(
    input  logic               clk,
    input  logic [A_W-1:0]     op_a,
    input  logic [A_W-1:0]     op_b,
    output logic [2*A_W-1:0]   prod
);

    logic [2*A_W-1:0] prod_reg;
    logic [2*A_W-1:0] prod_next;

    assign prod_next = (2*A_W)'(op_a) * (2*A_W)'(op_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

@@ rtl/core/mer_core.sv @@
// Sequencer and walk registers of the midpoint ellipse rasteriser.
module mer_core
    import mer_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   cmd,
    input  logic [COORD_BITS-1:0]  cx_in,
    input  logic [COORD_BITS-1:0]  cy_in,
    input  logic [RADIUS_BITS-1:0] rx_in,
    input  logic [RADIUS_BITS-1:0] ry_in,
    input  logic                   slot_free,
    output logic                   ready,
    output mer_emit_t              emit,
    output logic [RADIUS_BITS-1:0] step_x,
    output logic [RADIUS_BITS-1:0] step_y,
    output logic [COORD_BITS-1:0]  held_cx,
    output logic [COORD_BITS-1:0]  held_cy
);

    localparam int R     = RADIUS_BITS;
    localparam int SQ_W  = 2 * R;
    localparam int MA_W  = 2 * R + 2;
    localparam int P_W   = 2 * MA_W;
    localparam int DXY_W = 3 * R + 1;
    localparam int D_W   = 4 * R + 8;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_R1   = 2'd1;
    localparam logic [1:0] PH_R2   = 2'd2;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_ST1    = 5'd1;
    localparam logic [4:0] S_ST2    = 5'd2;
    localparam logic [4:0] S_ST3    = 5'd3;
    localparam logic [4:0] S_ST4    = 5'd4;
    localparam logic [4:0] S_R2_0   = 5'd5;
    localparam logic [4:0] S_R2_1   = 5'd6;
    localparam logic [4:0] S_R2_2   = 5'd7;
    localparam logic [4:0] S_R2_3   = 5'd8;
    localparam logic [4:0] S_R2_4   = 5'd9;
    localparam logic [4:0] S_R2_5   = 5'd10;
    localparam logic [4:0] S_N1_0   = 5'd11;
    localparam logic [4:0] S_N1_1   = 5'd12;
    localparam logic [4:0] S_N1_2   = 5'd13;
    localparam logic [4:0] S_N1_3   = 5'd14;
    localparam logic [4:0] S_N2_0   = 5'd15;
    localparam logic [4:0] S_N2_1   = 5'd16;
    localparam logic [4:0] S_N2_2   = 5'd17;
    localparam logic [4:0] S_N2_3   = 5'd18;
    localparam logic [4:0] S_SETTLE = 5'd19;
    localparam logic [4:0] S_EMIT   = 5'd20;

    // control state
    logic [4:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic       pv_reg, pv_next;
    logic       last_reg, last_next;

    // walk registers
    logic [R-1:0]            x_reg, x_next;
    logic [R-1:0]            y_reg, y_next;
    logic [COORD_BITS-1:0]   cx_reg, cx_next;
    logic [COORD_BITS-1:0]   cy_reg, cy_next;
    logic [SQ_W-1:0]         rx_sq_reg, rx_sq_next;
    logic [SQ_W-1:0]         ry_sq_reg, ry_sq_next;
    logic [DXY_W-1:0]        dx_reg, dx_next;
    logic [DXY_W-1:0]        dy_reg, dy_next;
    logic signed [D_W-1:0]   d_reg, d_next;
    logic [MA_W-1:0]         t_reg, t_next;
    logic                    flag_reg, flag_next;

    logic [MA_W-1:0]       mul_a, mul_b;
    logic [P_W-1:0]        prod;
    logic signed [D_W-1:0] prod4;
    logic signed [D_W-1:0] rx_sq4;
    logic signed [D_W-1:0] ry_sq4;
    logic signed [D_W-1:0] dx4;
    logic signed [D_W-1:0] dy4;
    logic [DXY_W-1:0]      rx_sq2;
    logic [DXY_W-1:0]      ry_sq2;
    logic [R-1:0]          y_dec;

    mer_mul #(
        .A_W (MA_W)
    ) u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign prod4  = D_W'(prod) <<< 2;
    assign rx_sq4 = D_W'(rx_sq_reg) <<< 2;
    assign ry_sq4 = D_W'(ry_sq_reg) <<< 2;
    assign dx4    = D_W'(dx_reg) <<< 2;
    assign dy4    = D_W'(dy_reg) <<< 2;
    assign rx_sq2 = DXY_W'({rx_sq_reg, 1'b0});
    assign ry_sq2 = DXY_W'({ry_sq_reg, 1'b0});
    assign y_dec  = y_reg - 1'b1;

    // Operand selection for the shared multiplier; the product is registered and taken in the state that follows.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_IDLE:
            begin
                mul_a = MA_W'(rx_in);
                mul_b = MA_W'(rx_in);
            end
            S_ST1:
            begin
                mul_a = MA_W'(y_reg);
                mul_b = MA_W'(y_reg);
            end
            S_ST2:
            begin
                mul_a = MA_W'(rx_sq_reg);
                mul_b = MA_W'(y_reg);
            end
            S_R2_0:
            begin
                mul_a = MA_W'({x_reg, 1'b1});
                mul_b = MA_W'({x_reg, 1'b1});
            end
            S_R2_1:
            begin
                mul_a = MA_W'(y_dec);
                mul_b = MA_W'(y_dec);
            end
            S_R2_2:
            begin
                mul_a = MA_W'(ry_sq_reg);
                mul_b = t_reg;
            end
            S_R2_3:
            begin
                mul_a = MA_W'(rx_sq_reg);
                mul_b = t_reg;
            end
            S_R2_4:
            begin
                mul_a = MA_W'(rx_sq_reg);
                mul_b = MA_W'(ry_sq_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        pv_next    = pv_reg;
        last_next  = last_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        rx_sq_next = rx_sq_reg;
        ry_sq_next = ry_sq_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        d_next     = d_reg;
        t_next     = t_reg;
        flag_next  = flag_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd == CMD_START)
                    begin
                        cx_next    = cx_in;
                        cy_next    = cy_in;
                        x_next     = '0;
                        y_next     = ry_in;
                        dx_next    = '0;
                        phase_next = PH_R1;
                        state_next = S_ST1;
                    end
                    else if (phase_reg == PH_R1)
                    begin
                        state_next = S_N1_0;
                    end
                    else if (phase_reg == PH_R2)
                    begin
                        state_next = S_N2_0;
                    end
                    else
                    begin
                        pv_next    = 1'b0;
                        last_next  = 1'b0;
                        state_next = S_EMIT;
                    end
                end
            end
            S_ST1:
            begin
                rx_sq_next = prod[SQ_W-1:0];
                state_next = S_ST2;
            end
            S_ST2:
            begin
                ry_sq_next = prod[SQ_W-1:0];
                state_next = S_ST3;
            end
            S_ST3:
            begin
                dy_next    = DXY_W'({prod, 1'b0});
                d_next     = D_W'(rx_sq_reg) - prod4;
                state_next = S_ST4;
            end
            S_ST4:
            begin
                d_next     = d_reg + ry_sq4;
                state_next = S_SETTLE;
            end
            S_R2_0:
            begin
                state_next = S_R2_1;
            end
            S_R2_1:
            begin
                t_next     = prod[MA_W-1:0];
                state_next = S_R2_2;
            end
            S_R2_2:
            begin
                t_next     = prod[MA_W-1:0];
                state_next = S_R2_3;
            end
            S_R2_3:
            begin
                d_next     = D_W'(prod);
                state_next = S_R2_4;
            end
            S_R2_4:
            begin
                d_next     = d_reg + prod4;
                state_next = S_R2_5;
            end
            S_R2_5:
            begin
                d_next     = d_reg - prod4;
                pv_next    = 1'b1;
                last_next  = 1'b0;
                state_next = S_EMIT;
            end
            S_N1_0:
            begin
                flag_next  = d_reg[D_W-1];
                x_next     = x_reg + 1'b1;
                dx_next    = dx_reg + ry_sq2;
                state_next = S_N1_1;
            end
            S_N1_1:
            begin
                d_next = d_reg + dx4;
                if (!flag_reg)
                begin
                    y_next  = y_dec;
                    dy_next = dy_reg - rx_sq2;
                end
                state_next = S_N1_2;
            end
            S_N1_2:
            begin
                d_next     = d_reg + ry_sq4;
                state_next = flag_reg ? S_SETTLE : S_N1_3;
            end
            S_N1_3:
            begin
                d_next     = d_reg - dy4;
                state_next = S_SETTLE;
            end
            S_N2_0:
            begin
                flag_next  = !d_reg[D_W-1] && (d_reg != '0);
                y_next     = y_dec;
                dy_next    = dy_reg - rx_sq2;
                state_next = S_N2_1;
            end
            S_N2_1:
            begin
                d_next = d_reg + rx_sq4;
                if (!flag_reg)
                begin
                    x_next  = x_reg + 1'b1;
                    dx_next = dx_reg + ry_sq2;
                end
                state_next = S_N2_2;
            end
            S_N2_2:
            begin
                d_next     = d_reg - dy4;
                state_next = flag_reg ? S_SETTLE : S_N2_3;
            end
            S_N2_3:
            begin
                d_next     = d_reg + dx4;
                state_next = S_SETTLE;
            end
            S_SETTLE:
            begin
                // Region 1 ends once the slope reaches one, i.e. 2ry^2x no longer below 2rx^2y.
                pv_next    = 1'b1;
                last_next  = 1'b0;
                state_next = S_EMIT;
                if (phase_reg == PH_R1 && !(dx_reg < dy_reg))
                begin
                    if (y_reg != '0)
                    begin
                        phase_next = PH_R2;
                        state_next = S_R2_0;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        last_next  = 1'b1;
                    end
                end
                else if (phase_reg == PH_R2 && y_reg == '0)
                begin
                    phase_next = PH_IDLE;
                    last_next  = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_IDLE;
            pv_reg    <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            pv_reg    <= pv_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        rx_sq_reg <= rx_sq_next;
        ry_sq_reg <= ry_sq_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        d_reg     <= d_next;
        t_reg     <= t_next;
        flag_reg  <= flag_next;
    end

    assign ready          = (state_reg == S_IDLE);
    assign emit.req       = (state_reg == S_EMIT);
    assign emit.pts_valid = pv_reg;
    assign emit.last      = last_reg;
    assign step_x         = x_reg;
    assign step_y         = y_reg;
    assign held_cx        = cx_reg;
    assign held_cy        = cy_reg;

endmodule

@@ rtl/core/midpoint_ellipse_raster.sv @@
// Top level of the midpoint ellipse rasteriser: stream ports, output register, point sums.
//
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tuser command, s_tdata centre and radii
// m_        out        m_tvalid/m_tready  m_tdata four points, m_tuser valid, m_tlast last set
//
// A start item passes the set-up states S_ST1 to S_ST4 and S_SETTLE, a next item the step
// states of its region and S_SETTLE; with no ellipse loaded a next item goes straight to
// S_EMIT. Entering region 2 adds states S_R2_0 to S_R2_5. The shared multiplier and the
// single decision accumulator, used one operation per cycle, set this sequence of states.
// Reset is asynchronous and active low and leaves the block idle with no ellipse loaded.
// A finished result waits in the emit state until the output register is free or being taken.
module midpoint_ellipse_raster
    import mer_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // center_x, center_y, radius_x, radius_y
    input  logic [((2*COORD_BITS+2*RADIUS_BITS+7)/8)*8-1:0] s_tdata,
    // command
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y
    output logic [((8*(COORD_BITS+1)+7)/8)*8-1:0] m_tdata,
    // points_valid
    output logic m_tuser,
    // final_set
    output logic m_tlast
);

    localparam int C     = COORD_BITS;
    localparam int R     = RADIUS_BITS;
    localparam int O_W   = C + 1;
    localparam int S_W   = ((C > R) ? C : R) + 2;
    localparam int OUT_W = ((8*O_W+7)/8)*8;

    logic            start;
    logic            core_ready;
    logic            slot_free;
    logic            load;
    mer_emit_t       emit;
    logic [R-1:0]    step_x, step_y;
    logic [C-1:0]    held_cx, held_cy;

    logic signed [S_W-1:0] cx_e, cy_e, x_e, y_e;
    logic [O_W-1:0]        px, mx, py, my;
    logic [OUT_W-1:0]      pts;

    logic             valid_reg, valid_next;
    logic             last_reg, last_next;
    logic             user_reg, user_next;
    logic [OUT_W-1:0] data_reg, data_next;

    assign start = s_tvalid && core_ready;

    mer_core #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (s_tuser),
        .cx_in     (s_tdata[C-1:0]),
        .cy_in     (s_tdata[2*C-1:C]),
        .rx_in     (s_tdata[2*C+R-1:2*C]),
        .ry_in     (s_tdata[2*C+2*R-1:2*C+R]),
        .slot_free (slot_free),
        .ready     (core_ready),
        .emit      (emit),
        .step_x    (step_x),
        .step_y    (step_y),
        .held_cx   (held_cx),
        .held_cy   (held_cy)
    );

    assign cx_e = S_W'(signed'(held_cx));
    assign cy_e = S_W'(signed'(held_cy));
    assign x_e  = signed'(S_W'(step_x));
    assign y_e  = signed'(S_W'(step_y));

    // Coordinates wrap to the output width.
    assign px = O_W'(cx_e + x_e);
    assign mx = O_W'(cx_e - x_e);
    assign py = O_W'(cy_e + y_e);
    assign my = O_W'(cy_e - y_e);

    assign pts = OUT_W'({my, mx, py, mx, my, px, py, px});

    assign slot_free = !valid_reg || m_tready;
    assign load      = emit.req && slot_free;

    always_comb
    begin
        valid_next = valid_reg;
        last_next  = last_reg;
        user_next  = user_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = 1'b1;
            user_next  = emit.pts_valid;
            last_next  = emit.pts_valid && emit.last;
            data_next  = emit.pts_valid ? pts : '0;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        user_reg <= user_next;
        data_reg <= data_next;
    end

    assign s_tready = core_ready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

@@ rtl/core/mer_chk.sv @@
// Port-level assertions for the midpoint ellipse rasteriser, bound to the top level.
module mer_chk
    import mer_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
)
(
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((8*(COORD_BITS+1)+7)/8)*8-1:0] m_tdata,
    input logic m_tuser,
    input logic m_tlast
);

    // Only a set of real points can close an ellipse.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("last set flagged without valid points");

    // An empty result carries no coordinates.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata == '0) && !m_tlast)
        else $error("empty result carries data");

    // The block works on one item at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // A new result appears only after the sequencer has been busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without preceding work");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind midpoint_ellipse_raster mer_chk #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
) u_mer_chk (.*);

@@ test/midpoint_ellipse_raster_test.sv @@
// Self-checking stream testbench for the midpoint ellipse rasteriser.
`timescale 1ns / 1ps

module midpoint_ellipse_raster_test
    import mer_pkg::*;
();

    localparam int  CYCLE_LIMIT  = 500000;
    localparam int  SETTLE_TIME  = 32;
    localparam int  PLAN_COPY    = 0;
    localparam int  CHECK_COPY   = 1;

    typedef enum logic [1:0] {
        WALK_IDLE    = 2'd0,
        WALK_REGION1 = 2'd1,
        WALK_REGION2 = 2'd2
    } walk_phase_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // center_x, center_y, radius_x, radius_y
    logic [47:0]  s_tdata = '0;
    // command
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y
    logic [103:0] m_tdata;
    // points_valid
    logic         m_tuser;
    // final_set
    logic         m_tlast;

    // Two copies of the walk state: one plans the stimulus, one checks the output.
    walk_phase_t walk_phase [2] = '{WALK_IDLE, WALK_IDLE};
    longint      walk_x     [2] = '{0, 0};
    longint      walk_y     [2] = '{0, 0};
    longint      walk_dec   [2] = '{0, 0};
    longint      hold_cx    [2] = '{0, 0};
    longint      hold_cy    [2] = '{0, 0};
    longint      rx_sq      [2] = '{0, 0};
    longint      ry_sq      [2] = '{0, 0};

    logic [48:0]  pending_items [$];
    logic [105:0] expected_sets [$];

    int  items_pushed = 0;
    int  results_done = 0;
    int  mismatches = 0;
    int  cycles = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  s_taken = 1'b0;

    midpoint_ellipse_raster u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Returns {final_set, points_valid, points} for one item and advances the walk.
    function automatic logic [105:0] next_point_set(int c, logic cmd, logic [47:0] data);
        longint      rx;
        longint      ry;
        longint      a;
        longint      b;
        logic [12:0] px_p;
        logic [12:0] px_m;
        logic [12:0] py_p;
        logic [12:0] py_m;
        if (cmd == CMD_START) begin
            rx = longint'(data[33:24]);
            ry = longint'(data[43:34]);
            hold_cx[c] = longint'($signed(data[11:0]));
            hold_cy[c] = longint'($signed(data[23:12]));
            rx_sq[c] = rx * rx;
            ry_sq[c] = ry * ry;
            walk_x[c] = 0;
            walk_y[c] = ry;
            walk_dec[c] = 4 * ry_sq[c] - 4 * rx_sq[c] * ry + rx_sq[c];
            walk_phase[c] = WALK_REGION1;
        end
        else if (walk_phase[c] == WALK_REGION1) begin
            walk_x[c]++;
            if (walk_dec[c] < 0)
                walk_dec[c] += 4 * (2 * ry_sq[c] * walk_x[c] + ry_sq[c]);
            else
            begin
                walk_y[c]--;
                walk_dec[c] += 4 * (2 * ry_sq[c] * walk_x[c] + ry_sq[c])
                               - 8 * rx_sq[c] * walk_y[c];
            end
        end
        else if (walk_phase[c] == WALK_REGION2) begin
            walk_y[c]--;
            if (walk_dec[c] > 0)
                walk_dec[c] += 4 * rx_sq[c] - 8 * rx_sq[c] * walk_y[c];
            else
            begin
                walk_x[c]++;
                walk_dec[c] += 8 * ry_sq[c] * walk_x[c] - 8 * rx_sq[c] * walk_y[c]
                               + 4 * rx_sq[c];
            end
        end
        else begin
            // A step with no ellipse loaded gives an all-zero item.
            return '0;
        end

        // Leave region 1 once the slope reaches one, then finish when y reaches zero.
        if (walk_phase[c] == WALK_REGION1 && !(ry_sq[c] * walk_x[c] < rx_sq[c] * walk_y[c]))
        begin
            walk_phase[c] = WALK_REGION2;
            if (walk_y[c] != 0) begin
                a = 2 * walk_x[c] + 1;
                b = walk_y[c] - 1;
                walk_dec[c] = ry_sq[c] * a * a + 4 * rx_sq[c] * b * b
                              - 4 * rx_sq[c] * ry_sq[c];
            end
        end
        if (walk_phase[c] == WALK_REGION2 && walk_y[c] == 0)
            walk_phase[c] = WALK_IDLE;

        px_p = 13'(hold_cx[c] + walk_x[c]);
        px_m = 13'(hold_cx[c] - walk_x[c]);
        py_p = 13'(hold_cy[c] + walk_y[c]);
        py_m = 13'(hold_cy[c] - walk_y[c]);
        return {walk_phase[c] == WALK_IDLE, 1'b1,
                py_m, px_m, py_p, px_m, py_m, px_p, py_p, px_p};
    endfunction

    function automatic logic [105:0] queue_item(logic cmd, logic [47:0] data);
        pending_items.push_back({cmd, data});
        items_pushed++;
        return next_point_set(PLAN_COPY, cmd, data);
    endfunction

    // Starts an ellipse and follows it with steps until its last set or max_next steps.
    task automatic push_walk(input logic [11:0] cx, input logic [11:0] cy,
                             input logic [9:0] rx, input logic [9:0] ry, input int max_next);
        logic [105:0] r;
        logic [43:0]  junk;
        int           n;
        n = 0;
        r = queue_item(CMD_START, {4'b0, ry, rx, cy, cx});
        while (!r[105] && n < max_next) begin
            junk = 44'({$urandom, $urandom});
            r = queue_item(CMD_NEXT, {4'b0, junk});
            n++;
        end
    endtask

    task automatic queue_idle_step();
        logic [43:0]  junk;
        junk = 44'({$urandom, $urandom});
        void'(queue_item(CMD_NEXT, {4'b0, junk}));
    endtask

    task automatic gen_random(input int count);
        logic [43:0]  junk;
        int           stop_at;
        int           sel;
        int           max_next;
        int           lim;
        stop_at = items_pushed + count;
        while (items_pushed < stop_at) begin
            if ($urandom_range(0, 99) < 10) begin
                junk = 44'({$urandom, $urandom});
                void'(queue_item(1'($urandom_range(0, 1)), {4'b0, junk}));
            end
            else begin
                sel = $urandom_range(0, 9);
                lim = (sel < 6) ? 12 : (sel < 9) ? 40 : 1023;
                if (sel == 9)
                    max_next = $urandom_range(3, 30);
                else if ($urandom_range(0, 9) == 0)
                    max_next = $urandom_range(0, 5);
                else
                    max_next = 100000;
                push_walk(12'($urandom), 12'($urandom), 10'($urandom_range(0, lim)),
                          10'($urandom_range(0, lim)), max_next);
                if ($urandom_range(0, 4) == 0)
                    queue_idle_step();
            end
        end
    endtask

    task automatic drain();
        while (results_done != items_pushed)
            @(negedge clk);
    endtask

    // Acceptance, prediction, checking and the run limit all sit on the rising edge.
    always @(posedge clk) begin
        logic [105:0] want;
        logic [105:0] got;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
        s_taken <= s_tvalid && s_tready;
        if (rst_n && m_tvalid && m_tready) begin
            got = {m_tlast, m_tuser, m_tdata};
            if (expected_sets.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing expected, expected none actual %h",
                         $time, got);
            end
            else begin
                want = expected_sets.pop_front();
                for (int f = 0; f < 10; f++) begin
                    if (want[13 * f +: 13] !== got[13 * f +: 13] && f < 8
                        || f >= 8 && want[96 + f] !== got[96 + f]) begin
                        mismatches++;
                        if (f < 8)
                            $display("%0t: field %0d expected %0d actual %0d", $time, f,
                                     $signed(want[13 * f +: 13]),
                                     $signed(got[13 * f +: 13]));
                        else
                            $display("%0t: flag %0d expected %b actual %b", $time, f,
                                     want[96 + f], got[96 + f]);
                    end
                end
                results_done++;
            end
        end
        if (rst_n && s_tvalid && s_tready)
            expected_sets.push_back(next_point_set(CHECK_COPY, s_tuser, s_tdata));
    end

    // Sender: a new item goes out only once the previous one has been taken.
    always @(negedge clk) begin
        if (rst_n && (!s_tvalid || s_taken)) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                {s_tuser, s_tdata} <= pending_items.pop_front();
                s_tvalid <= 1'b1;
            end
            else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver, with one long hold-off so that the block backs up into its input.
    always @(negedge clk) begin
        static int hold_left = 0;
        static bit hold_used = 1'b0;
        if (!hold_used && results_done >= 200) begin
            hold_used = 1'b1;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 16;
        recv_idle_pct = 47;
        queue_idle_step();
        push_walk(12'sd0, 12'sd0, 10'd3, 10'd2, 100);
        push_walk(-12'sd5, 12'sd7, 10'd0, 10'd4, 100);
        push_walk(12'sd10, -12'sd10, 10'd6, 10'd0, 100);
        queue_idle_step();
        push_walk(12'h7ff, 12'h7ff, 10'd1023, 10'd1023, 2);
        push_walk(12'h800, 12'h800, 10'd1023, 10'd1023, 2);
        push_walk(12'h800, 12'h7ff, 10'd0, 10'd0, 100);
        push_walk(12'h7ff, 12'h800, 10'd1023, 10'd0, 100);
        push_walk(12'sd1, -12'sd1, 10'd1, 10'd1, 100);
        // Queue nothing more until every set so far has come back.
        drain();
        gen_random(450);
        drain();

        send_idle_pct = 47;
        recv_idle_pct = 16;
        gen_random(450);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        gen_random(450);
        drain();

        repeat (SETTLE_TIME) @(negedge clk);
        if (mismatches == 0 && expected_sets.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ midpoint_ellipse_raster.f @@
rtl/core/mer_pkg.sv
rtl/core/mer_mul.sv
rtl/core/mer_core.sv
rtl/core/midpoint_ellipse_raster.sv
rtl/core/mer_chk.sv
test/midpoint_ellipse_raster_test.sv
